>>> rtl/gpio_controller_with_event_detect_defines.svh
// Assertion macros shared by the GPIO controller RTL.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef GPIO_CONTROLLER_WITH_EVENT_DETECT_DEFINES_SVH
`define GPIO_CONTROLLER_WITH_EVENT_DETECT_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define GPIO_ED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define GPIO_ED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/gpio_ed_pkg.sv
// Types, constants and mask helpers for the GPIO controller with event detect.
// Used by gpio_ed_core and gpio_controller_with_event_detect; depends on nothing.
`timescale 1ns / 1ps

package gpio_ed_pkg;

  // Pin count limits and defaults.
  localparam int MaxPins         = 64;
  localparam int NumPinsDef      = 58;
  localparam int BankLowLastDef  = 27;
  localparam int BankMidLastDef  = 45;

  // Bus word and register index widths.
  localparam int DataW = 32;
  localparam int IdxW  = 5;

  // Function select packing: 10 pins of 3 bits in each of 6 words.
  localparam int FselWords   = 6;
  localparam int FselPerWord = 10;
  localparam int FselBits    = 3;
  localparam int FselW       = FselPerWord * FselBits;
  localparam logic [FselBits-1:0] FselOutput = 3'd1;

  // Pull control packing: 16 pins of 2 bits in each of 4 words.
  localparam int PullWords   = 4;
  localparam int PullPerWord = 16;
  localparam int PullBits    = 2;

  // Register map.
  localparam logic [IdxW-1:0] RegFselLast = 5'd5;
  localparam logic [IdxW-1:0] RegSetLo    = 5'd6;
  localparam logic [IdxW-1:0] RegSetHi    = 5'd7;
  localparam logic [IdxW-1:0] RegClrHi    = 5'd9;
  localparam logic [IdxW-1:0] RegLevHi    = 5'd11;
  localparam logic [IdxW-1:0] RegEvsHi    = 5'd13;
  localparam logic [IdxW-1:0] RegRiseLo   = 5'd14;
  localparam logic [IdxW-1:0] RegLowHi    = 5'd21;
  localparam logic [IdxW-1:0] RegPullLo   = 5'd22;
  localparam logic [IdxW-1:0] RegPullLast = 5'd25;

  // Detect enable groups, in register order.
  localparam logic [1:0] GrpRise = 2'd0;
  localparam logic [1:0] GrpFall = 2'd1;
  localparam logic [1:0] GrpHigh = 2'd2;
  localparam logic [1:0] GrpLow  = 2'd3;

  typedef enum logic [1:0] {
    ModeRead   = 2'd0,
    ModeWrite  = 2'd1,
    ModeSample = 2'd2
  } mode_e;

  typedef logic [FselWords-1:0][FselW-1:0] fsel_words_t;
  typedef logic [PullWords-1:0][DataW-1:0] pull_words_t;

  // Command handed from the input stage to the register core.
  typedef struct packed {
    logic            fire;
    mode_e           mode;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // Bank interrupt lines.
  typedef struct packed {
    logic low;
    logic mid;
    logic high;
  } irq_t;

  // Writable bits of each function select word for a given pin count.
  function automatic fsel_words_t fsel_masks(int npins);
    fsel_words_t m;
    m = '0;
    for (int w = 0; w < FselWords; w++) begin
      for (int k = 0; k < FselPerWord; k++) begin
        if (w * FselPerWord + k < npins) begin
          m[w][k*FselBits +: FselBits] = '1;
        end
      end
    end
    return m;
  endfunction

  // Writable bits of each pull control word for a given pin count.
  function automatic pull_words_t pull_masks(int npins);
    pull_words_t m;
    m = '0;
    for (int w = 0; w < PullWords; w++) begin
      for (int k = 0; k < PullPerWord; k++) begin
        if (w * PullPerWord + k < npins) begin
          m[w][k*PullBits +: PullBits] = '1;
        end
      end
    end
    return m;
  endfunction

  // Ones at pins first..last.
  function automatic logic [MaxPins-1:0] range_mask(int first, int last);
    logic [MaxPins-1:0] m;
    m = '0;
    for (int p = 0; p < MaxPins; p++) begin
      m[p] = (p >= first) && (p <= last);
    end
    return m;
  endfunction

endpackage

>>> rtl/gpio_ed_core.sv
// Register file and per-pin event logic of the GPIO controller.
// Depends on gpio_ed_pkg and gpio_controller_with_event_detect_defines.svh.
`timescale 1ns / 1ps

`include "gpio_controller_with_event_detect_defines.svh"

module gpio_ed_core #(
  parameter int NUM_PINS      = gpio_ed_pkg::NumPinsDef,
  parameter int BANK_LOW_LAST = gpio_ed_pkg::BankLowLastDef,
  parameter int BANK_MID_LAST = gpio_ed_pkg::BankMidLastDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gpio_ed_pkg::cmd_t              cmd_i,
  input  logic [gpio_ed_pkg::DataW-1:0]  write_data_i,
  input  logic [NUM_PINS-1:0]            pin_levels_i,
  output logic [gpio_ed_pkg::DataW-1:0]  read_data_o,
  output logic [NUM_PINS-1:0]            pin_drive_o,
  output logic [NUM_PINS-1:0]            pin_output_enable_o,
  output gpio_ed_pkg::irq_t              irq_o
);

  localparam int HiW = NUM_PINS - gpio_ed_pkg::DataW;
  localparam int FselPins = gpio_ed_pkg::FselWords * gpio_ed_pkg::FselPerWord;

  localparam gpio_ed_pkg::fsel_words_t FselMask = gpio_ed_pkg::fsel_masks(NUM_PINS);
  localparam gpio_ed_pkg::pull_words_t PullMask = gpio_ed_pkg::pull_masks(NUM_PINS);

  localparam logic [gpio_ed_pkg::MaxPins-1:0] LoHalf64 =
    gpio_ed_pkg::range_mask(0, gpio_ed_pkg::DataW - 1);
  localparam logic [gpio_ed_pkg::MaxPins-1:0] BankLo64 =
    gpio_ed_pkg::range_mask(0, BANK_LOW_LAST);
  localparam logic [gpio_ed_pkg::MaxPins-1:0] BankMid64 =
    gpio_ed_pkg::range_mask(BANK_LOW_LAST + 1, BANK_MID_LAST);
  localparam logic [gpio_ed_pkg::MaxPins-1:0] BankHi64 =
    gpio_ed_pkg::range_mask(BANK_MID_LAST + 1, NUM_PINS - 1);

  localparam logic [NUM_PINS-1:0] LoHalf  = LoHalf64[NUM_PINS-1:0];
  localparam logic [NUM_PINS-1:0] BankLo  = BankLo64[NUM_PINS-1:0];
  localparam logic [NUM_PINS-1:0] BankMid = BankMid64[NUM_PINS-1:0];
  localparam logic [NUM_PINS-1:0] BankHi  = BankHi64[NUM_PINS-1:0];

  // Architectural state.
  gpio_ed_pkg::fsel_words_t fsel_q, fsel_d;
  gpio_ed_pkg::pull_words_t pull_q, pull_d;
  logic [NUM_PINS-1:0] latch_q, latch_d;
  logic [NUM_PINS-1:0] rise_q, rise_d;
  logic [NUM_PINS-1:0] fall_q, fall_d;
  logic [NUM_PINS-1:0] high_q, high_d;
  logic [NUM_PINS-1:0] low_q, low_d;
  logic [NUM_PINS-1:0] evs_q, evs_d;
  logic [NUM_PINS-1:0] lev_q, lev_d;

  // Decode helpers.
  logic [gpio_ed_pkg::IdxW-1:0] en_off;
  logic [gpio_ed_pkg::IdxW-1:0] pull_off;
  logic [1:0]                   en_grp;
  logic                         hi_half;
  logic [NUM_PINS-1:0]          wbits;
  logic [NUM_PINS-1:0]          half_mask;
  logic [NUM_PINS-1:0]          rd_src;
  logic [gpio_ed_pkg::DataW-1:0] rd_hi;
  logic [gpio_ed_pkg::DataW-1:0] rd_half;
  logic [NUM_PINS-1:0]          ev;

  assign en_off   = cmd_i.idx - gpio_ed_pkg::RegRiseLo;
  assign pull_off = cmd_i.idx - gpio_ed_pkg::RegPullLo;
  assign en_grp   = en_off[2:1];
  assign hi_half  = cmd_i.idx[0];
  assign half_mask = hi_half ? ~LoHalf : LoHalf;

  // Spread the written word onto the pins of the addressed half.
  always_comb begin
    wbits = '0;
    if (hi_half) begin
      wbits[NUM_PINS-1:gpio_ed_pkg::DataW] = write_data_i[HiW-1:0];
    end else begin
      wbits[gpio_ed_pkg::DataW-1:0] = write_data_i;
    end
  end

  // Pin-wide register that a half-word read targets.
  always_comb begin
    rd_src = lev_q;
    if (cmd_i.idx <= gpio_ed_pkg::RegLevHi) begin
      rd_src = lev_q;
    end else if (cmd_i.idx <= gpio_ed_pkg::RegEvsHi) begin
      rd_src = evs_q;
    end else begin
      unique case (en_grp)
        gpio_ed_pkg::GrpRise: rd_src = rise_q;
        gpio_ed_pkg::GrpFall: rd_src = fall_q;
        gpio_ed_pkg::GrpHigh: rd_src = high_q;
        gpio_ed_pkg::GrpLow:  rd_src = low_q;
        default:              rd_src = low_q;
      endcase
    end
  end

  // Select the low or high word of that register; upper pins read zero.
  always_comb begin
    rd_hi = '0;
    rd_hi[HiW-1:0] = rd_src[NUM_PINS-1:gpio_ed_pkg::DataW];
    rd_half = hi_half ? rd_hi : rd_src[gpio_ed_pkg::DataW-1:0];
  end

  // Edge and level events from the new sample against the previous one.
  assign ev = (pin_levels_i & ~lev_q & rise_q) | (~pin_levels_i & lev_q & fall_q) |
              (pin_levels_i & high_q) | (~pin_levels_i & low_q);

  // Next state and read data for the command being executed.
  always_comb begin
    fsel_d  = fsel_q;
    pull_d  = pull_q;
    latch_d = latch_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    high_d  = high_q;
    low_d   = low_q;
    evs_d   = evs_q;
    lev_d   = lev_q;
    read_data_o = '0;
    if (cmd_i.fire) begin
      unique case (cmd_i.mode)
        gpio_ed_pkg::ModeRead: begin
          priority if (cmd_i.idx <= gpio_ed_pkg::RegFselLast) begin
            read_data_o = {{(gpio_ed_pkg::DataW - gpio_ed_pkg::FselW){1'b0}},
                           fsel_q[cmd_i.idx[2:0]]};
          end else if (cmd_i.idx <= gpio_ed_pkg::RegClrHi) begin
            read_data_o = '0;
          end else if (cmd_i.idx <= gpio_ed_pkg::RegLowHi) begin
            read_data_o = rd_half;
          end else if (cmd_i.idx <= gpio_ed_pkg::RegPullLast) begin
            read_data_o = pull_q[pull_off[1:0]];
          end else begin
            read_data_o = '0;
          end
        end
        gpio_ed_pkg::ModeWrite: begin
          priority if (cmd_i.idx <= gpio_ed_pkg::RegFselLast) begin
            fsel_d[cmd_i.idx[2:0]] =
              write_data_i[gpio_ed_pkg::FselW-1:0] & FselMask[cmd_i.idx[2:0]];
          end else if (cmd_i.idx <= gpio_ed_pkg::RegSetHi) begin
            latch_d = latch_q | wbits;
          end else if (cmd_i.idx <= gpio_ed_pkg::RegClrHi) begin
            latch_d = latch_q & ~wbits;
          end else if (cmd_i.idx <= gpio_ed_pkg::RegLevHi) begin
            lev_d = lev_q;
          end else if (cmd_i.idx <= gpio_ed_pkg::RegEvsHi) begin
            evs_d = evs_q & ~wbits;
          end else if (cmd_i.idx <= gpio_ed_pkg::RegLowHi) begin
            unique case (en_grp)
              gpio_ed_pkg::GrpRise: rise_d = (rise_q & ~half_mask) | wbits;
              gpio_ed_pkg::GrpFall: fall_d = (fall_q & ~half_mask) | wbits;
              gpio_ed_pkg::GrpHigh: high_d = (high_q & ~half_mask) | wbits;
              gpio_ed_pkg::GrpLow:  low_d  = (low_q & ~half_mask) | wbits;
              default:              low_d  = low_q;
            endcase
          end else if (cmd_i.idx <= gpio_ed_pkg::RegPullLast) begin
            pull_d[pull_off[1:0]] = write_data_i & PullMask[pull_off[1:0]];
          end else begin
            lev_d = lev_q;
          end
        end
        gpio_ed_pkg::ModeSample: begin
          evs_d = evs_q | ev;
          lev_d = pin_levels_i;
        end
        default: begin
          lev_d = lev_q;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q  <= '0;
      pull_q  <= '0;
      latch_q <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
      high_q  <= '0;
      low_q   <= '0;
      evs_q   <= '0;
      lev_q   <= '0;
    end else begin
      fsel_q  <= fsel_d;
      pull_q  <= pull_d;
      latch_q <= latch_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      high_q  <= high_d;
      low_q   <= low_d;
      evs_q   <= evs_d;
      lev_q   <= lev_d;
    end
  end

  // Output enables follow the updated function select; pins past the
  // function select words never drive.
  for (genvar w = 0; w < gpio_ed_pkg::FselWords; w++) begin : g_oe_word
    for (genvar k = 0; k < gpio_ed_pkg::FselPerWord; k++) begin : g_oe_pin
      if (w * gpio_ed_pkg::FselPerWord + k < NUM_PINS) begin : g_used
        assign pin_output_enable_o[w * gpio_ed_pkg::FselPerWord + k] =
          (fsel_d[w][k*gpio_ed_pkg::FselBits +: gpio_ed_pkg::FselBits] ==
           gpio_ed_pkg::FselOutput);
      end
    end
  end
  for (genvar p = FselPins; p < NUM_PINS; p++) begin : g_oe_none
    assign pin_output_enable_o[p] = 1'b0;
  end

  // Result view of the updated state.
  assign pin_drive_o = latch_d;
  assign irq_o.low   = |(evs_d & BankLo);
  assign irq_o.mid   = |(evs_d & BankMid);
  assign irq_o.high  = |(evs_d & BankHi);

  // Levels move only on a sample.
  `GPIO_ED_ASSERT(a_lev_only_on_sample,
    !(cmd_i.fire && cmd_i.mode == gpio_ed_pkg::ModeSample) |=> $stable(lev_q),
    "pin level changed without a sample")
  // Event bits are only ever set by a sample.
  `GPIO_ED_ASSERT(a_evs_set_by_sample,
    !(cmd_i.fire && cmd_i.mode == gpio_ed_pkg::ModeSample) |=>
      ((evs_q & ~$past(evs_q)) == '0),
    "event bit set outside a sample")
  // The set and clear registers read back as zero.
  `GPIO_ED_ASSERT(a_setclr_read_zero,
    (cmd_i.fire && cmd_i.mode == gpio_ed_pkg::ModeRead &&
     cmd_i.idx >= gpio_ed_pkg::RegSetLo && cmd_i.idx <= gpio_ed_pkg::RegClrHi) |->
      (read_data_o == '0),
    "set or clear register read nonzero")

endmodule

>>> rtl/gpio_controller_with_event_detect.sv
// Top level of the GPIO controller with event detect: input register,
// result register and handshakes. Depends on gpio_ed_pkg, gpio_ed_core and
// gpio_controller_with_event_detect_defines.svh.
//
// Usage: each input word is a register read, a register write or a sample of
// all pin levels (mode_i). Every accepted word yields exactly one result word
// holding read data (zero unless a read), the output latch, the per-pin output
// enables and the three bank interrupt lines, all taken after the update.
// Both channels use valid/ready. An accepted word waits in the input register
// until the result register is free or being emptied, then executes and its
// result is loaded into the result register, from which it is offered. One
// word is accepted and one result delivered every cycle while the receiver
// keeps ready high; the single input register and the single result register
// set that rate.
// When the receiver stalls, the result register holds its word, the pending
// input word waits in the input register and in_ready_o drops once both are
// full. Reset clears all registers to zero: every pin is an input, nothing is
// driven, no event is pending and both channels are empty.
`timescale 1ns / 1ps

`include "gpio_controller_with_event_detect_defines.svh"

module gpio_controller_with_event_detect #(
  parameter int NUM_PINS      = gpio_ed_pkg::NumPinsDef,
  parameter int BANK_LOW_LAST = gpio_ed_pkg::BankLowLastDef,
  parameter int BANK_MID_LAST = gpio_ed_pkg::BankMidLastDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [gpio_ed_pkg::IdxW-1:0]  reg_index_i,
  input  logic [gpio_ed_pkg::DataW-1:0] write_data_i,
  input  logic [NUM_PINS-1:0]           pin_levels_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gpio_ed_pkg::DataW-1:0] read_data_o,
  output logic [NUM_PINS-1:0]           pin_drive_o,
  output logic [NUM_PINS-1:0]           pin_output_enable_o,
  output logic                          irq_bank_low_o,
  output logic                          irq_bank_mid_o,
  output logic                          irq_bank_high_o
);

  // Input register.
  logic                          in_valid_q;
  logic [1:0]                    mode_q;
  logic [gpio_ed_pkg::IdxW-1:0]  idx_q;
  logic [gpio_ed_pkg::DataW-1:0] data_q;
  logic [NUM_PINS-1:0]           levels_q;

  // Result register.
  logic                          out_valid_q;
  logic [gpio_ed_pkg::DataW-1:0] rd_q;
  logic [NUM_PINS-1:0]           drive_q;
  logic [NUM_PINS-1:0]           oe_q;
  gpio_ed_pkg::irq_t             irq_q;

  // Core results for the word being executed.
  logic [gpio_ed_pkg::DataW-1:0] rd_d;
  logic [NUM_PINS-1:0]           drive_d;
  logic [NUM_PINS-1:0]           oe_d;
  gpio_ed_pkg::irq_t             irq_d;

  gpio_ed_pkg::cmd_t cmd;
  logic              fire;
  logic              in_take;

  // The held word executes when the result register is free or being emptied.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  assign cmd.fire = fire;
  assign cmd.mode = gpio_ed_pkg::mode_e'(mode_q);
  assign cmd.idx  = idx_q;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !fire);
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      idx_q    <= '0;
      data_q   <= '0;
      levels_q <= '0;
    end else if (in_take) begin
      mode_q   <= mode_i;
      idx_q    <= reg_index_i;
      data_q   <= write_data_i;
      levels_q <= pin_levels_i;
    end
  end

  gpio_ed_core #(
    .NUM_PINS      (NUM_PINS),
    .BANK_LOW_LAST (BANK_LOW_LAST),
    .BANK_MID_LAST (BANK_MID_LAST)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .write_data_i        (data_q),
    .pin_levels_i        (levels_q),
    .read_data_o         (rd_d),
    .pin_drive_o         (drive_d),
    .pin_output_enable_o (oe_d),
    .irq_o               (irq_d)
  );

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire || (out_valid_q && !out_ready_i);
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      drive_q <= '0;
      oe_q    <= '0;
      irq_q   <= '0;
    end else if (fire) begin
      rd_q    <= rd_d;
      drive_q <= drive_d;
      oe_q    <= oe_d;
      irq_q   <= irq_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rd_q;
  assign pin_drive_o         = drive_q;
  assign pin_output_enable_o = oe_q;
  assign irq_bank_low_o      = irq_q.low;
  assign irq_bank_mid_o      = irq_q.mid;
  assign irq_bank_high_o     = irq_q.high;

  // An executed word always lands in the result register.
  `GPIO_ED_ASSERT(a_fire_gives_result, fire |=> out_valid_q,
    "executed word produced no result")
  // A word never executes over a stalled result.
  `GPIO_ED_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |-> !fire,
    "result overwritten while stalled")
  // A waiting word stays in the input register until it executes.
  `GPIO_ED_ASSERT(a_input_held, (in_valid_q && !fire) |=> (in_valid_q && $stable(idx_q)),
    "pending input word lost")
  // Reset leaves both registers empty.
  `GPIO_ED_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!in_valid_q && !out_valid_q),
    "registers not empty in reset")

endmodule

>>> bench/gpio_controller_with_event_detect_checker.sv
// Checker for the GPIO controller with event detect: follows both handshakes,
// predicts every result word and compares it field by field.
// Depends on gpio_ed_pkg for widths, modes, register map and detect groups.
`timescale 1ns / 1ps

module gpio_controller_with_event_detect_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    mode_i,
  input  logic [gpio_ed_pkg::IdxW-1:0]  reg_index_i,
  input  logic [gpio_ed_pkg::DataW-1:0] write_data_i,
  input  logic [gpio_ed_pkg::NumPinsDef-1:0] pin_levels_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [gpio_ed_pkg::DataW-1:0] read_data_i,
  input  logic [gpio_ed_pkg::NumPinsDef-1:0] pin_drive_i,
  input  logic [gpio_ed_pkg::NumPinsDef-1:0] pin_output_enable_i,
  input  logic                          irq_bank_low_i,
  input  logic                          irq_bank_mid_i,
  input  logic                          irq_bank_high_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  import gpio_ed_pkg::*;

  localparam int NumPins = NumPinsDef;

  // Pin masks kept 64 bits wide so the half-word registers line up directly.
  localparam logic [63:0] PinMask  = (64'd1 << NumPins) - 64'd1;
  localparam logic [63:0] LowBank  = (64'd1 << (BankLowLastDef + 1)) - 64'd1;
  localparam logic [63:0] UpToMid  = (64'd1 << (BankMidLastDef + 1)) - 64'd1;
  localparam logic [63:0] MidBank  = UpToMid & ~LowBank;
  localparam logic [63:0] HighBank = PinMask & ~UpToMid;

  typedef struct packed {
    logic [DataW-1:0]   rdata;
    logic [NumPins-1:0] drive;
    logic [NumPins-1:0] oe;
    logic               irq_low;
    logic               irq_mid;
    logic               irq_high;
  } gpio_result_t;

  // Predicted register state of the controller.
  logic [DataW-1:0] fsel_q [FselWords];
  logic [DataW-1:0] pull_q [PullWords];
  logic [63:0]      detect_en [4];
  logic [63:0]      latch_q;
  logic [63:0]      status_q;
  logic [63:0]      level_q;

  gpio_result_t pending_results [$];
  gpio_result_t want;
  int           mismatch_count;

  // Ones over the implemented pins of a packed word.
  function automatic logic [DataW-1:0] field_mask(int first, int count, int width);
    logic [DataW-1:0] m;
    m = '0;
    for (int k = 0; k < count; k++) begin
      if (first + k < NumPins) begin
        m |= ((DataW'(1) << width) - DataW'(1)) << (k * width);
      end
    end
    return m;
  endfunction

  // A bus word placed on the low or high half of the pin vector.
  function automatic logic [63:0] place_half(logic [DataW-1:0] w, logic hi);
    return (hi ? {w, 32'h0} : {32'h0, w}) & PinMask;
  endfunction

  function automatic logic [DataW-1:0] pick_half(logic [63:0] v, logic hi);
    return hi ? v[63:32] : v[31:0];
  endfunction

  // Applies one accepted word to the predicted state and returns its result.
  function automatic gpio_result_t apply_gpio_word(logic [1:0] mode, logic [IdxW-1:0] idx,
                                                   logic [DataW-1:0] data,
                                                   logic [NumPins-1:0] lev_in);
    gpio_result_t r;
    logic [63:0]  lev;
    logic [63:0]  ev;
    logic [63:0]  oe;
    logic [DataW-1:0] rd;
    logic         hi;
    int           grp;
    lev = 64'(lev_in);
    rd  = '0;
    hi  = idx[0];
    grp = (int'(idx) - int'(RegRiseLo)) / 2;
    case (mode)
      ModeRead: begin
        if (idx <= RegFselLast) begin
          rd = fsel_q[idx];
        end else if (idx <= RegClrHi) begin
          // Set and clear are write-only.
          rd = '0;
        end else if (idx <= RegLevHi) begin
          rd = pick_half(level_q, hi);
        end else if (idx <= RegEvsHi) begin
          rd = pick_half(status_q, hi);
        end else if (idx <= RegLowHi) begin
          rd = pick_half(detect_en[grp], hi);
        end else if (idx <= RegPullLast) begin
          rd = pull_q[idx - RegPullLo];
        end
      end
      ModeWrite: begin
        if (idx <= RegFselLast) begin
          fsel_q[idx] = data & field_mask(int'(idx) * FselPerWord, FselPerWord, FselBits);
        end else if (idx <= RegSetHi) begin
          latch_q |= place_half(data, hi);
        end else if (idx <= RegClrHi) begin
          latch_q &= ~place_half(data, hi);
        end else if (idx <= RegLevHi) begin
          // The level register ignores writes.
        end else if (idx <= RegEvsHi) begin
          status_q &= ~place_half(data, hi);
        end else if (idx <= RegLowHi) begin
          detect_en[grp] = ((detect_en[grp] & (hi ? 64'h0000_0000_FFFF_FFFF
                                                  : 64'hFFFF_FFFF_0000_0000))
                            | place_half(data, hi)) & PinMask;
        end else if (idx <= RegPullLast) begin
          pull_q[idx - RegPullLo] = data & field_mask((int'(idx) - int'(RegPullLo)) * PullPerWord,
                                                      PullPerWord, PullBits);
        end
      end
      ModeSample: begin
        // Edges compare against the previous sample; levels need no history.
        ev = (lev & ~level_q & detect_en[GrpRise]) | (~lev & level_q & detect_en[GrpFall])
           | (lev & detect_en[GrpHigh]) | (~lev & detect_en[GrpLow]);
        status_q = (status_q | ev) & PinMask;
        level_q  = lev;
      end
      default: begin
      end
    endcase

    // A pin drives when its function select holds the output code.
    oe = '0;
    for (int p = 0; p < NumPins; p++) begin
      oe[p] = fsel_q[p / FselPerWord][FselBits * (p % FselPerWord) +: FselBits] == FselOutput;
    end

    r.rdata    = rd;
    r.drive    = latch_q[NumPins-1:0];
    r.oe       = oe[NumPins-1:0];
    r.irq_low  = |(status_q & LowBank);
    r.irq_mid  = |(status_q & MidBank);
    r.irq_high = |(status_q & HighBank);
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
  endtask

  // Results are retired before new words are predicted, since a word accepted
  // at this edge cannot have its result taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < FselWords; w++) fsel_q[w] = '0;
      for (int w = 0; w < PullWords; w++) pull_q[w] = '0;
      for (int g = 0; g < 4; g++) detect_en[g] = '0;
      latch_q  = '0;
      status_q = '0;
      level_q  = '0;
      pending_results.delete();
      mismatch_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with nothing expected, expected none, got read data %h",
                   $time, read_data_i);
        end else begin
          want = pending_results.pop_front();
          if (read_data_i !== want.rdata) begin
            note_mismatch("read_data", 64'(want.rdata), 64'(read_data_i));
          end
          if (pin_drive_i !== want.drive) begin
            note_mismatch("pin_drive", 64'(want.drive), 64'(pin_drive_i));
          end
          if (pin_output_enable_i !== want.oe) begin
            note_mismatch("pin_output_enable", 64'(want.oe), 64'(pin_output_enable_i));
          end
          if (irq_bank_low_i !== want.irq_low) begin
            note_mismatch("irq_bank_low", 64'(want.irq_low), 64'(irq_bank_low_i));
          end
          if (irq_bank_mid_i !== want.irq_mid) begin
            note_mismatch("irq_bank_mid", 64'(want.irq_mid), 64'(irq_bank_mid_i));
          end
          if (irq_bank_high_i !== want.irq_high) begin
            note_mismatch("irq_bank_high", 64'(want.irq_high), 64'(irq_bank_high_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(apply_gpio_word(mode_i, reg_index_i, write_data_i,
                                                  pin_levels_i));
      end
      fail_count_o <= mismatch_count;
      pending_o    <= pending_results.size();
    end
  end

endmodule

>>> bench/gpio_controller_with_event_detect_tb.sv
// Testbench top for the GPIO controller with event detect: clock, reset,
// directed and random bus words, random stalls on both sides and the verdict.
// Depends on gpio_ed_pkg, the controller RTL and the checker module.
`timescale 1ns / 1ps

module gpio_controller_with_event_detect_tb;

  import gpio_ed_pkg::*;

  localparam int NumPins       = NumPinsDef;
  localparam int RandomWords   = 800;
  localparam int HoldOffCycles = 80;
  localparam int IdleLimit     = 1000;
  localparam int DrainCycles   = 8;

  // Further register index names; all but RegPullHi are unnamed in the package map.
  localparam logic [IdxW-1:0] RegFselFirst = 5'd0;
  localparam logic [IdxW-1:0] RegClrLo     = 5'd8;
  localparam logic [IdxW-1:0] RegLevLo     = 5'd10;
  localparam logic [IdxW-1:0] RegEvsLo     = 5'd12;
  localparam logic [IdxW-1:0] RegFallHi    = 5'd17;
  localparam logic [IdxW-1:0] RegHighHi    = 5'd19;
  localparam logic [IdxW-1:0] RegLowLo     = 5'd20;
  localparam logic [IdxW-1:0] RegPullHi    = 5'd25;
  localparam logic [IdxW-1:0] RegUnknownLo = 5'd26;
  localparam logic [IdxW-1:0] RegUnknownHi = 5'd31;

  localparam logic [1:0]       ModeUnused    = 2'd3;
  // Function select word with every pin set to output.
  localparam logic [DataW-1:0] FselAllOutput = 32'h0924_9249;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic [IdxW-1:0]    reg_index_i;
  logic [DataW-1:0]   write_data_i;
  logic [NumPins-1:0] pin_levels_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [DataW-1:0]   read_data_o;
  logic [NumPins-1:0] pin_drive_o;
  logic [NumPins-1:0] pin_output_enable_o;
  logic               irq_bank_low_o;
  logic               irq_bank_mid_o;
  logic               irq_bank_high_o;

  int fail_count;
  int pending_count;
  int idle_cycles;
  bit random_started;
  bit hold_done;

  gpio_controller_with_event_detect uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .reg_index_i         (reg_index_i),
    .write_data_i        (write_data_i),
    .pin_levels_i        (pin_levels_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .read_data_o         (read_data_o),
    .pin_drive_o         (pin_drive_o),
    .pin_output_enable_o (pin_output_enable_o),
    .irq_bank_low_o      (irq_bank_low_o),
    .irq_bank_mid_o      (irq_bank_mid_o),
    .irq_bank_high_o     (irq_bank_high_o)
  );

  gpio_controller_with_event_detect_checker gpio_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .mode_i              (mode_i),
    .reg_index_i         (reg_index_i),
    .write_data_i        (write_data_i),
    .pin_levels_i        (pin_levels_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .read_data_i         (read_data_o),
    .pin_drive_i         (pin_drive_o),
    .pin_output_enable_i (pin_output_enable_o),
    .irq_bank_low_i      (irq_bank_low_o),
    .irq_bank_mid_i      (irq_bank_mid_o),
    .irq_bank_high_i     (irq_bank_high_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending_count)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("[gpio_controller_with_event_detect] ERROR");
        $finish;
      end
    end
  end

  // Sender gap: no gaps while the receiver holds off, otherwise mostly short.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (random_started && !hold_done) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offers one word and holds it until accepted; valid drops only for a gap.
  task automatic send_word(input logic [1:0] mode, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] data, input logic [NumPins-1:0] lev,
                           input int gap);
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    reg_index_i  <= idx;
    write_data_i <= data;
    pin_levels_i <= lev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: one long hold-off at the start of the random part, then random
  // runs of ready and stalls, with an occasional long run without stalls.
  initial begin : receiver
    int   left;
    logic ready_level;
    left        = 0;
    ready_level = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (random_started && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_done = 1'b1;
        left      = 0;
      end else begin
        if (left == 0) begin
          ready_level = !ready_level;
          if (ready_level) begin
            left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
          end else begin
            left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
          end
        end
        out_ready_i <= ready_level;
        left--;
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned        r;
    logic [1:0]         mode;
    logic [IdxW-1:0]    idx;
    logic [DataW-1:0]   data;
    logic [NumPins-1:0] levels;
    logic [63:0]        wide;
    logic [63:0]        flips;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = ModeRead;
    reg_index_i    = '0;
    write_data_i   = '0;
    pin_levels_i   = '0;
    random_started = 1'b0;
    levels         = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: packing limits, write-only and read-only registers,
    // unknown indexes, the unused mode and every kind of detect.
    send_word(ModeRead,   RegFselFirst, '0, '0, pick_gap());
    send_word(ModeWrite,  RegFselFirst, FselAllOutput, '0, pick_gap());
    send_word(ModeWrite,  RegFselLast,  '1, '0, pick_gap());
    send_word(ModeRead,   RegFselLast,  '0, '0, pick_gap());
    send_word(ModeWrite,  RegSetLo,     '1, '0, pick_gap());
    send_word(ModeWrite,  RegSetHi,     '1, '0, pick_gap());
    send_word(ModeRead,   RegSetLo,     '0, '0, pick_gap());
    send_word(ModeWrite,  RegClrHi,     32'h5555_5555, '0, pick_gap());
    send_word(ModeRead,   RegClrLo,     '0, '0, pick_gap());
    send_word(ModeWrite,  RegRiseLo,    '1, '0, pick_gap());
    send_word(ModeWrite,  RegFallHi,    '1, '0, pick_gap());
    send_word(ModeWrite,  RegHighHi,    32'h0000_0200, '0, pick_gap());
    send_word(ModeWrite,  RegLowLo,     32'h0000_0001, '0, pick_gap());
    send_word(ModeSample, RegFselFirst, '0, '1, pick_gap());
    send_word(ModeRead,   RegLevHi,     '0, '1, pick_gap());
    send_word(ModeSample, RegFselFirst, '1, '0, pick_gap());
    send_word(ModeRead,   RegEvsLo,     '0, '0, pick_gap());
    send_word(ModeWrite,  RegEvsLo,     '1, '0, pick_gap());
    send_word(ModeWrite,  RegEvsHi,     '1, '0, pick_gap());
    send_word(ModeWrite,  RegLevLo,     '1, '1, pick_gap());
    send_word(ModeWrite,  RegPullHi,    '1, '0, pick_gap());
    send_word(ModeRead,   RegPullLast,  '0, '0, pick_gap());
    send_word(ModeWrite,  RegUnknownHi, '1, '0, pick_gap());
    send_word(ModeRead,   RegUnknownLo, '1, '1, pick_gap());
    send_word(ModeUnused, RegFselFirst, '1, '1, pick_gap());

    // Random words: mostly known registers, with samples that flip a sparse
    // set of pins so that edges stay selective, and some full random levels.
    random_started = 1'b1;
    for (int n = 0; n < RandomWords; n++) begin
      r = $urandom_range(0, 99);
      mode = (r < 34) ? ModeRead : (r < 68) ? ModeWrite : (r < 94) ? ModeSample : ModeUnused;
      idx = ($urandom_range(0, 9) == 0) ? IdxW'($urandom_range(26, 31))
                                        : IdxW'($urandom_range(0, 25));
      r = $urandom_range(0, 9);
      data = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? FselAllOutput : $urandom();
      wide  = {$urandom(), $urandom()};
      flips = {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
      r = $urandom_range(0, 19);
      if (r == 0) begin
        levels = '0;
      end else if (r == 1) begin
        levels = '1;
      end else if (r < 7) begin
        levels = wide[NumPins-1:0];
      end else begin
        levels = levels ^ flips[NumPins-1:0];
      end
      send_word(mode, idx, data, levels, pick_gap());
    end

    // Wait out every expected result, then drain for strays.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[gpio_controller_with_event_detect] OK");
    end else begin
      $display("[gpio_controller_with_event_detect] ERROR");
    end
    $finish;
  end

endmodule
